>>> rtl/mnee_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnee_pkg
// Types and constants shared by the MIDI note event encoder.
// ----------------------------------------------------------------------------
package mnee_pkg;

  // Item modes
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_NOTE  = 2'd1;
  localparam logic [1:0] MODE_END   = 2'd2;

  // Configuration register indexes
  localparam logic CFG_VELOCITY   = 1'b0;
  localparam logic CFG_KEY_OFFSET = 1'b1;

  // Reset values of the configuration registers
  localparam logic [6:0] VELOCITY_RST   = 7'd127;
  localparam logic [5:0] KEY_OFFSET_RST = 6'd20;

  // Fixed bytes
  localparam logic [7:0] BYTE_ZERO     = 8'h00;
  localparam logic [7:0] BYTE_PROG_CHG = 8'hc0;
  localparam logic [7:0] BYTE_PROG_NUM = 8'h01;
  localparam logic [7:0] BYTE_META     = 8'hff;
  localparam logic [7:0] BYTE_EOT      = 8'h2f;
  localparam logic [7:0] BYTE_NOTE_ON  = 8'h90;
  localparam logic [7:0] BYTE_NOTE_OFF = 8'h80;
  localparam logic [7:0] VLQ_MORE      = 8'h80;

  // Byte buffer: five delta bytes, status, note, velocity
  localparam int unsigned BUF_DEPTH = 8;
  localparam int unsigned BUF_IDX_W = $clog2(BUF_DEPTH);

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] timestamp;
    logic [6:0]  key;
    logic        pressed;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        last;
    logic [31:0] byte_count;
  } out_item_t;

endpackage

>>> rtl/midi_note_event_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_note_event_encoder
// Turns start, note and end items into MIDI track body bytes with a running
// byte count.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+------------------------------
//  in_      | input     | in_valid / in_stall | mode, timestamp, key, pressed
//  out_     | output    | out_valid/out_stall | out_byte, last, byte_count
//  cfg_     | input     | cfg_wr_en           | cfg_index, cfg_data
//
//  Each item gives as many bytes on the byte-wide output as listed here:
//  3 for a start item, 4 for an end item, 4 to 8 for a note item
//  (1 to 5 delta bytes plus three event bytes). An unused mode is dropped as
//  it leaves the input register. Items follow each other with no gap.
//  The first byte passes the input register, byte buffer and output register.
//  Reset (rst_n low, synchronous) empties all stages, restores velocity
//  127 and key offset 20, zeroes the byte count and the previous time.
//  A stall on the output holds the current byte; the input register and
//  the byte buffer keep accepting until both are full.
// ----------------------------------------------------------------------------
module midi_note_event_encoder (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mnee_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mnee_pkg::out_item_t  out_data,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_index,
  input  logic [6:0]           cfg_data
);

  // Configuration registers
  logic [6:0] velocity_r;
  logic [5:0] key_offset_r;

  // Track state
  logic [31:0] prev_time_r;
  logic        first_pending_r;
  logic [31:0] track_bytes_r;
  logic [31:0] track_bytes_nxt;

  // Input register
  logic                in_vld_r;
  mnee_pkg::in_item_t  in_q_r;

  // Byte buffer of the item being sent
  logic                          buf_vld_r;
  logic [7:0]                    buf_bytes_r [mnee_pkg::BUF_DEPTH];
  logic [mnee_pkg::BUF_IDX_W-1:0] buf_idx_r;
  logic [mnee_pkg::BUF_IDX_W-1:0] buf_end_r;
  logic                          buf_clr_r;

  // Output register
  logic                 out_vld_r;
  mnee_pkg::out_item_t  out_q_r;

  // Load path
  logic                          load_en;
  logic                          ld_has;
  logic                          ld_clr;
  logic [7:0]                    ld_bytes [mnee_pkg::BUF_DEPTH];
  logic [mnee_pkg::BUF_IDX_W-1:0] ld_start;
  logic [mnee_pkg::BUF_IDX_W-1:0] ld_end;
  logic [31:0]                   delta;
  logic [mnee_pkg::BUF_IDX_W-1:0] vlq_start;

  // Send path
  logic mv_en;
  logic buf_last;
  logic buf_done;

  // --------------------------------------------------------------------------
  // Handshake control
  // --------------------------------------------------------------------------
  // Move a byte into the output register whenever it is empty or draining.
  assign mv_en    = buf_vld_r && (!out_vld_r || !out_stall);
  assign buf_last = (buf_idx_r == buf_end_r);
  assign buf_done = mv_en && buf_last;
  // Take the next item into the buffer as the last byte of the current leaves.
  assign load_en  = in_vld_r && (!buf_vld_r || buf_done);
  assign in_stall = in_vld_r && !load_en;

  assign out_valid = out_vld_r;
  assign out_data  = out_q_r;

  // --------------------------------------------------------------------------
  // Item decode: delta time as VLQ groups and the byte list
  // --------------------------------------------------------------------------
  always_comb begin
    delta = first_pending_r ? 32'd0 : (in_q_r.timestamp - prev_time_r);

    // Drop leading zero groups; the final group is always sent.
    if (delta[31:28] != 4'd0) begin
      vlq_start = 3'd0;
    end else if (delta[27:21] != 7'd0) begin
      vlq_start = 3'd1;
    end else if (delta[20:14] != 7'd0) begin
      vlq_start = 3'd2;
    end else if (delta[13:7] != 7'd0) begin
      vlq_start = 3'd3;
    end else begin
      vlq_start = 3'd4;
    end

    for (int i = 0; i < mnee_pkg::BUF_DEPTH; i++) begin
      ld_bytes[i] = mnee_pkg::BYTE_ZERO;
    end
    ld_has   = 1'b1;
    ld_clr   = 1'b0;
    ld_start = '0;
    ld_end   = '0;

    unique case (in_q_r.mode)
      mnee_pkg::MODE_START: begin
        ld_bytes[0] = mnee_pkg::BYTE_ZERO;
        ld_bytes[1] = mnee_pkg::BYTE_PROG_CHG;
        ld_bytes[2] = mnee_pkg::BYTE_PROG_NUM;
        ld_end      = 3'd2;
        ld_clr      = 1'b1;
      end
      mnee_pkg::MODE_NOTE: begin
        ld_bytes[0] = mnee_pkg::VLQ_MORE | {4'd0, delta[31:28]};
        ld_bytes[1] = mnee_pkg::VLQ_MORE | {1'b0, delta[27:21]};
        ld_bytes[2] = mnee_pkg::VLQ_MORE | {1'b0, delta[20:14]};
        ld_bytes[3] = mnee_pkg::VLQ_MORE | {1'b0, delta[13:7]};
        ld_bytes[4] = {1'b0, delta[6:0]};
        ld_bytes[5] = in_q_r.pressed ? mnee_pkg::BYTE_NOTE_ON : mnee_pkg::BYTE_NOTE_OFF;
        ld_bytes[6] = {1'b0, in_q_r.key} + {2'b00, key_offset_r};
        ld_bytes[7] = {1'b0, velocity_r};
        ld_start    = vlq_start;
        ld_end      = 3'd7;
      end
      mnee_pkg::MODE_END: begin
        ld_bytes[0] = mnee_pkg::BYTE_ZERO;
        ld_bytes[1] = mnee_pkg::BYTE_META;
        ld_bytes[2] = mnee_pkg::BYTE_EOT;
        ld_bytes[3] = mnee_pkg::BYTE_ZERO;
        ld_end      = 3'd3;
      end
      default: begin
        // Unused mode: drop the item with no bytes.
        ld_has = 1'b0;
      end
    endcase
  end

  // Running count: a start item restarts it at its first byte.
  assign track_bytes_nxt = (buf_clr_r ? 32'd0 : track_bytes_r) + 32'd1;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      velocity_r   <= mnee_pkg::VELOCITY_RST;
      key_offset_r <= mnee_pkg::KEY_OFFSET_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        mnee_pkg::CFG_VELOCITY:   velocity_r   <= cfg_data;
        mnee_pkg::CFG_KEY_OFFSET: key_offset_r <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_vld_r <= 1'b1;
    end else if (load_en) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q_r <= in_data;
    end
  end

  // --------------------------------------------------------------------------
  // Track state, advanced as items enter the buffer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_time_r     <= 32'd0;
      first_pending_r <= 1'b1;
    end else if (load_en) begin
      if (in_q_r.mode == mnee_pkg::MODE_START) begin
        first_pending_r <= 1'b1;
      end else if (in_q_r.mode == mnee_pkg::MODE_NOTE) begin
        prev_time_r     <= in_q_r.timestamp;
        first_pending_r <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Byte buffer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_vld_r <= 1'b0;
      buf_clr_r <= 1'b0;
    end else if (load_en) begin
      buf_vld_r <= ld_has;
      buf_clr_r <= ld_clr;
    end else if (mv_en) begin
      // Clear only applies to the first byte sent.
      buf_clr_r <= 1'b0;
      if (buf_last) begin
        buf_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      for (int i = 0; i < mnee_pkg::BUF_DEPTH; i++) begin
        buf_bytes_r[i] <= ld_bytes[i];
      end
      buf_idx_r <= ld_start;
      buf_end_r <= ld_end;
    end else if (mv_en) begin
      buf_idx_r <= buf_idx_r + 3'd1;
    end
  end

  // --------------------------------------------------------------------------
  // Output register and byte count
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r     <= 1'b0;
      track_bytes_r <= 32'd0;
    end else if (mv_en) begin
      out_vld_r     <= 1'b1;
      track_bytes_r <= track_bytes_nxt;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mv_en) begin
      out_q_r.out_byte   <= buf_bytes_r[buf_idx_r];
      out_q_r.last       <= buf_last;
      out_q_r.byte_count <= track_bytes_nxt;
    end
  end

endmodule

>>> tb/tb_midi_note_event_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_midi_note_event_encoder
// Self-checking bench for the MIDI note event encoder. Directed tracks cover
// the fixed start and end byte runs, every delta-time length, ignored items,
// out-of-range keys and both register extremes. Random tracks then follow
// under changing velocity and key offset settings. A built-in encoder
// computes the expected track bytes with their running count for each
// accepted item, and every output transfer is compared against it.
// ----------------------------------------------------------------------------
module tb_midi_note_event_encoder;

  // Mode code the block must drop without emitting anything
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam int unsigned DRAIN_TAIL     = 12;   // input register plus byte buffer
  localparam int unsigned WATCHDOG_LIMIT = 2000; // cycles with no transfer at all
  localparam int unsigned RANDOM_ITEMS   = 120;
  localparam int unsigned PHASE_ITEMS    = 30;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  mnee_pkg::in_item_t  in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  mnee_pkg::out_item_t out_data;
  logic                cfg_wr_en = 1'b0;
  logic                cfg_index = mnee_pkg::CFG_VELOCITY;
  logic [6:0]          cfg_data  = '0;

  midi_note_event_encoder u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow of the block: register copies and track state after reset
  logic [6:0]  velocity_q     = mnee_pkg::VELOCITY_RST;
  logic [5:0]  key_offset_q   = mnee_pkg::KEY_OFFSET_RST;
  logic [31:0] last_note_time = '0;
  logic        first_note_due = 1'b1;
  logic [31:0] byte_total     = '0;

  // Track bytes still owed by the block, oldest first
  mnee_pkg::out_item_t track_byte_q[$];

  int unsigned error_count = 0;
  int unsigned items_sent  = 0;
  int unsigned quiet_cycles = 0;
  bit          idling_on   = 1'b1;
  logic [31:0] now_ms      = '0;

  // Output side bookkeeping
  mnee_pkg::out_item_t want;
  int unsigned stall_left  = 0;
  int unsigned stall_draw;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Encoder: append the bytes one accepted item produces, tag each with the
  // running track count, flag the final one.
  // --------------------------------------------------------------------------
  function automatic void encode_event(mnee_pkg::in_item_t item);
    logic [7:0]  run [8];
    int          n = 0;
    logic [31:0] delta;
    logic [6:0]  grp;
    bit          started = 1'b0;
    case (item.mode)
      mnee_pkg::MODE_START: begin
        // Restart the count and the delta reference, then emit program change
        byte_total     = '0;
        first_note_due = 1'b1;
        run[0] = mnee_pkg::BYTE_ZERO;
        run[1] = mnee_pkg::BYTE_PROG_CHG;
        run[2] = mnee_pkg::BYTE_PROG_NUM;
        n = 3;
      end
      mnee_pkg::MODE_NOTE: begin
        delta = first_note_due ? 32'd0 : item.timestamp - last_note_time;
        // Top group holds only four bits; drop leading zero groups
        if (delta[31:28] != 4'd0) begin
          run[n] = mnee_pkg::VLQ_MORE | {4'd0, delta[31:28]};
          n++;
          started = 1'b1;
        end
        for (int g = 1; g <= 4; g++) begin
          grp = 7'(delta >> (28 - 7 * g));
          if (started || grp != 7'd0 || g == 4) begin
            started = 1'b1;
            run[n] = (g == 4) ? {1'b0, grp} : (mnee_pkg::VLQ_MORE | {1'b0, grp});
            n++;
          end
        end
        run[n]     = item.pressed ? mnee_pkg::BYTE_NOTE_ON : mnee_pkg::BYTE_NOTE_OFF;
        run[n + 1] = 8'(item.key) + 8'(key_offset_q);
        run[n + 2] = {1'b0, velocity_q};
        n += 3;
        last_note_time = item.timestamp;
        first_note_due = 1'b0;
      end
      mnee_pkg::MODE_END: begin
        run[0] = mnee_pkg::BYTE_ZERO;
        run[1] = mnee_pkg::BYTE_META;
        run[2] = mnee_pkg::BYTE_EOT;
        run[3] = mnee_pkg::BYTE_ZERO;
        n = 4;
      end
      default: return;
    endcase
    for (int k = 0; k < n; k++) begin
      byte_total = byte_total + 32'd1;
      track_byte_q.push_back('{out_byte: run[k], last: (k == n - 1), byte_count: byte_total});
    end
  endfunction

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Idle for a random gap, present the item, hold it until the transfer.
  // Valid stays high on return so a back-to-back item needs no fresh assertion of valid.
  task automatic send_item(mnee_pkg::in_item_t item);
    int unsigned gap;
    gap = idling_on ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    encode_event(item);
    if (item.mode != MODE_UNUSED) items_sent++;
  endtask

  task automatic send_note(logic [31:0] ts, logic [6:0] key, logic pressed);
    mnee_pkg::in_item_t item;
    item.mode      = mnee_pkg::MODE_NOTE;
    item.timestamp = ts;
    item.key       = key;
    item.pressed   = pressed;
    send_item(item);
  endtask

  // Start, end or unused item; fill the fields it ignores with noise
  task automatic send_marker(logic [1:0] mode);
    mnee_pkg::in_item_t item;
    item.mode      = mode;
    item.timestamp = $urandom;
    item.key       = 7'($urandom_range(0, 127));
    item.pressed   = 1'($urandom_range(0, 1));
    send_item(item);
  endtask

  // Drop valid, wait for every owed byte, then let the pipeline settle so a
  // trailing unused item is surely gone before registers change.
  task automatic wait_track_idle();
    in_valid <= 1'b0;
    while (track_byte_q.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  // Only called while idle; update the shadow copy with the write
  task automatic write_reg(logic idx, logic [6:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == mnee_pkg::CFG_VELOCITY) velocity_q = val;
    else key_offset_q = val[5:0];
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Output side: check each transfer against the oldest owed byte, then
  // draw the stall to hold before the next one.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (track_byte_q.size() == 0) begin
        $display("%0t: unexpected byte %02h last %0b count %0d", $time,
                 out_data.out_byte, out_data.last, out_data.byte_count);
        error_count++;
      end else begin
        want = track_byte_q.pop_front();
        if (out_data.out_byte !== want.out_byte) begin
          $display("%0t: out_byte expected %02h actual %02h", $time,
                   want.out_byte, out_data.out_byte);
          error_count++;
        end
        if (out_data.last !== want.last) begin
          $display("%0t: last expected %0b actual %0b", $time, want.last, out_data.last);
          error_count++;
        end
        if (out_data.byte_count !== want.byte_count) begin
          $display("%0t: byte_count expected %0d actual %0d", $time,
                   want.byte_count, out_data.byte_count);
          error_count++;
        end
      end
      stall_draw = idling_on ? $urandom_range(0, 4) : 0;
      out_stall  <= (stall_draw != 0);
      stall_left <= stall_draw;
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end
  end

  // Abort when neither channel has moved for too long
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset settings: first note carries a zero delta, so does a repeated time
  task automatic test_first_events();
    send_marker(mnee_pkg::MODE_START);
    now_ms = 32'd1000;
    send_note(now_ms, 7'd0, 1'b1);
    send_note(now_ms, 7'd87, 1'b0);
    send_marker(mnee_pkg::MODE_END);
  endtask

  // Walk the delta across every length boundary, then step back in time so
  // the difference wraps to all ones
  task automatic test_delta_lengths();
    logic [31:0] steps [8] = '{32'h0000_007f, 32'h0000_0080, 32'h0000_3fff,
                               32'h0000_4000, 32'h001f_ffff, 32'h0020_0000,
                               32'h0fff_ffff, 32'h1000_0000};
    foreach (steps[i]) begin
      now_ms = now_ms + steps[i];
      send_note(now_ms, 7'($urandom_range(0, 87)), 1'(i % 2));
    end
    now_ms = now_ms - 32'd1;
    send_note(now_ms, 7'd44, 1'b1);
  endtask

  // Unused mode, a key beyond the keyboard, and a start mid-stream that
  // makes the next note count as first again
  task automatic test_odd_items();
    send_marker(MODE_UNUSED);
    now_ms = now_ms + 32'd5;
    send_note(now_ms, 7'd127, 1'b1);
    send_marker(mnee_pkg::MODE_START);
    now_ms = 32'd0;
    send_note(now_ms, 7'd60, 1'b0);
    send_marker(mnee_pkg::MODE_END);
  endtask

  task automatic test_register_extremes();
    wait_track_idle();
    write_reg(mnee_pkg::CFG_VELOCITY, 7'd0);
    write_reg(mnee_pkg::CFG_KEY_OFFSET, 7'd0);
    send_marker(mnee_pkg::MODE_START);
    send_note(32'hffff_ffff, 7'd0, 1'b0);
    send_note(32'h0000_0000, 7'd127, 1'b1);
    send_marker(mnee_pkg::MODE_END);
    wait_track_idle();
    write_reg(mnee_pkg::CFG_VELOCITY, 7'd127);
    write_reg(mnee_pkg::CFG_KEY_OFFSET, 7'd40);
    send_note(32'h8000_0000, 7'd127, 1'b1);
    send_note(32'h8000_0123, 7'd87, 1'b0);
    send_marker(mnee_pkg::MODE_END);
  endtask

  // Mostly complete tracks with random deltas of every length; the rest is
  // noise: stray notes, stray starts and ends, unused items
  task automatic test_random_tracks();
    int unsigned        base;
    int unsigned        phase_base;
    int unsigned        phase = 0;
    int unsigned        notes;
    int unsigned        bits;
    logic [31:0]        delta;
    mnee_pkg::in_item_t item;
    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      wait_track_idle();
      write_reg(mnee_pkg::CFG_VELOCITY, 7'($urandom_range(0, 127)));
      write_reg(mnee_pkg::CFG_KEY_OFFSET, 7'($urandom_range(0, 40)));
      // Every fourth phase runs with both sides at full rate
      idling_on  = (phase % 4 != 3);
      phase_base = items_sent;
      while (items_sent - phase_base < PHASE_ITEMS && items_sent - base < RANDOM_ITEMS) begin
        if ($urandom_range(0, 4) != 0) begin
          send_marker(mnee_pkg::MODE_START);
          notes = $urandom_range(1, 6);
          repeat (notes) begin
            bits  = 7 * $urandom_range(1, 5);
            delta = (bits >= 32) ? $urandom : ($urandom & ((32'd1 << bits) - 32'd1));
            now_ms = now_ms + delta;
            send_note(now_ms,
                      ($urandom_range(0, 9) == 0) ? 7'($urandom_range(88, 127))
                                                  : 7'($urandom_range(0, 87)),
                      1'($urandom_range(0, 1)));
          end
          send_marker(mnee_pkg::MODE_END);
        end else begin
          item.mode      = 2'($urandom_range(0, 3));
          item.timestamp = $urandom;
          item.key       = 7'($urandom_range(0, 127));
          item.pressed   = 1'($urandom_range(0, 1));
          send_item(item);
        end
      end
      phase++;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_first_events();
    test_delta_lengths();
    test_odd_items();
    test_register_extremes();
    test_random_tracks();
    wait_track_idle();
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
